@@ design/utf8cf_pkg.sv @@
// Shared types and constants for the UTF-8 case fold transcoder.
// No dependencies; imported by all modules and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package utf8cf_pkg;

  // Codepoint limits and surrogate range
  localparam logic [20:0] CpMax     = 21'h10FFFF;
  localparam logic [20:0] SurrLo    = 21'h00D800;
  localparam logic [20:0] SurrHi    = 21'h00DFFF;

  // Overlong minimums by sequence length class
  localparam logic [20:0] MinTwo    = 21'h000080;
  localparam logic [20:0] MinThree  = 21'h000800;
  localparam logic [20:0] MinFour   = 21'h010000;

  // Length class codes (continuation bytes in the sequence)
  localparam logic [1:0] LenTwo     = 2'd1;
  localparam logic [1:0] LenThree   = 2'd2;
  localparam logic [1:0] LenFour    = 2'd3;

  // Result queue geometry
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned BurstMax   = 4;

  // One output beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } entry_t;

  // Up to four output beats produced by one input beat
  typedef struct packed {
    logic [2:0]        cnt;
    entry_t [3:0]      ent;
  } burst_t;

endpackage

`default_nettype wire

@@ design/utf8cf_if.sv @@
// Stream interfaces for input bytes and folded output bytes.
// Depends on nothing beyond plain logic types.
`timescale 1ns / 1ps
`default_nettype none

interface utf8cf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface utf8cf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       error;

  modport source (output valid, output out_byte, output out_last, output error,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input error,
                  output ready);
endinterface

`default_nettype wire

@@ design/utf8cf_decoder.sv @@
// Strict UTF-8 decoder with sequence state, simple case fold and re-encoder.
// Depends on utf8cf_pkg; emits one burst of up to four beats per accepted byte.
`timescale 1ns / 1ps
`default_nettype none

module utf8cf_decoder
  import utf8cf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output burst_t          burst_o
);

  logic [20:0] accum_q, accum_d;
  logic [1:0]  left_q, left_d;
  logic [1:0]  lclass_q, lclass_d;
  logic        discard_q, discard_d;

  // Simple case fold over the covered scripts
  function automatic logic [20:0] fold_cp(input logic [20:0] v);
    logic [20:0] r;
    r = v;
    if (v >= 21'h41 && v <= 21'h5A) r = v + 21'h20;
    else if ((v >= 21'hC0 && v <= 21'hD6) || (v >= 21'hD8 && v <= 21'hDE)) r = v + 21'h20;
    else if (v == 21'h178) r = 21'hFF;
    else if (v >= 21'h100 && v <= 21'h177 && !v[0]) r = v + 21'h1;
    else if (v >= 21'h391 && v <= 21'h3A1) r = v + 21'h20;
    else if (v >= 21'h3A3 && v <= 21'h3AB) r = v + 21'h20;
    else if (v == 21'h3C2) r = 21'h3C3;
    else if (v >= 21'h410 && v <= 21'h42F) r = v + 21'h20;
    else if (v >= 21'h400 && v <= 21'h40F) r = v + 21'h50;
    else if (v >= 21'hFF21 && v <= 21'hFF3A) r = v + 21'h20;
    else if (v == 21'h1E9E) r = 21'hDF;
    else if (v == 21'h212A) r = 21'h6B;
    return r;
  endfunction

  // Encode a codepoint as one to four beats, last flag on the final one
  function automatic burst_t encode_cp(input logic [20:0] cp, input logic last);
    burst_t b;
    b = '0;
    if (cp <= 21'h7F) begin
      b.cnt = 3'd1;
      b.ent[0] = '{data: cp[7:0], last: last, err: 1'b0};
    end else if (cp <= 21'h7FF) begin
      b.cnt = 3'd2;
      b.ent[0] = '{data: {3'b110, cp[10:6]}, last: 1'b0, err: 1'b0};
      b.ent[1] = '{data: {2'b10, cp[5:0]}, last: last, err: 1'b0};
    end else if (cp <= 21'hFFFF) begin
      b.cnt = 3'd3;
      b.ent[0] = '{data: {4'b1110, cp[15:12]}, last: 1'b0, err: 1'b0};
      b.ent[1] = '{data: {2'b10, cp[11:6]}, last: 1'b0, err: 1'b0};
      b.ent[2] = '{data: {2'b10, cp[5:0]}, last: last, err: 1'b0};
    end else begin
      b.cnt = 3'd4;
      b.ent[0] = '{data: {5'b11110, cp[20:18]}, last: 1'b0, err: 1'b0};
      b.ent[1] = '{data: {2'b10, cp[17:12]}, last: 1'b0, err: 1'b0};
      b.ent[2] = '{data: {2'b10, cp[11:6]}, last: 1'b0, err: 1'b0};
      b.ent[3] = '{data: {2'b10, cp[5:0]}, last: last, err: 1'b0};
    end
    return b;
  endfunction

  burst_t      err_burst;
  logic [20:0] accum_next;
  logic [20:0] min_cp;
  logic        fail;

  always_comb begin
    err_burst = '0;
    err_burst.cnt = 3'd1;
    err_burst.ent[0] = '{data: 8'h00, last: 1'b1, err: 1'b1};
  end

  // Continuation shift and overlong minimum for the current class
  assign accum_next = {accum_q[14:0], byte_i[5:0]};

  always_comb begin
    case (lclass_q)
      LenTwo:   min_cp = MinTwo;
      LenThree: min_cp = MinThree;
      default:  min_cp = MinFour;
    endcase
  end

  // Decode one byte: update sequence state and build the burst
  always_comb begin
    accum_d   = accum_q;
    left_d    = left_q;
    lclass_d  = lclass_q;
    discard_d = discard_q;
    burst_o   = '0;
    fail      = 1'b0;

    if (accept_i) begin
      if (discard_q) begin
        if (last_i) discard_d = 1'b0;
      end else if (left_q == 2'd0) begin
        if (!byte_i[7]) begin
          burst_o = encode_cp(fold_cp({13'd0, byte_i}), last_i);
        end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
          accum_d = {16'd0, byte_i[4:0]};
          lclass_d = LenTwo;
          left_d = LenTwo;
          fail = last_i;
        end else if (byte_i >= 8'hE0 && byte_i <= 8'hEF) begin
          accum_d = {17'd0, byte_i[3:0]};
          lclass_d = LenThree;
          left_d = LenThree;
          fail = last_i;
        end else if (byte_i >= 8'hF0 && byte_i <= 8'hF4) begin
          accum_d = {18'd0, byte_i[2:0]};
          lclass_d = LenFour;
          left_d = LenFour;
          fail = last_i;
        end else begin
          fail = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        fail = 1'b1;
      end else if (left_q != 2'd1) begin
        accum_d = accum_next;
        left_d = left_q - 2'd1;
        fail = last_i;
      end else begin
        // Sequence complete: range checks, then fold and re-encode
        accum_d = '0;
        left_d = 2'd0;
        lclass_d = 2'd0;
        if (accum_next < min_cp || accum_next > CpMax ||
            (accum_next >= SurrLo && accum_next <= SurrHi)) begin
          fail = 1'b1;
        end else begin
          burst_o = encode_cp(fold_cp(accum_next), last_i);
        end
      end

      // Error: single error beat, clear state, drop up to the string end
      if (fail) begin
        burst_o   = err_burst;
        accum_d   = '0;
        left_d    = 2'd0;
        lclass_d  = 2'd0;
        discard_d = !last_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q   <= '0;
      left_q    <= '0;
      lclass_q  <= '0;
      discard_q <= 1'b0;
    end else begin
      accum_q   <= accum_d;
      left_q    <= left_d;
      lclass_q  <= lclass_d;
      discard_q <= discard_d;
    end
  end

endmodule

`default_nettype wire

@@ design/utf8cf_queue.sv @@
// Result queue: takes a burst of up to four beats per cycle, sends one beat per cycle while ready.
// Depends on utf8cf_pkg and utf8cf_out_if.
`timescale 1ns / 1ps
`default_nettype none

module utf8cf_queue
  import utf8cf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  burst_t            burst_i,
  output logic              space_o,
  utf8cf_out_if.source      out_o
);

  entry_t               mem_q [QueueDepth];
  logic [QueueAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]     count_q, count_d;
  logic                 pop;

  // Room for a full burst
  assign space_o = count_q <= (QueueAw+1)'(QueueDepth - BurstMax);

  // Present the head beat
  assign pop            = out_o.valid && out_o.ready;
  assign out_o.valid    = count_q != '0;
  assign out_o.out_byte = mem_q[rd_ptr_q].data;
  assign out_o.out_last = mem_q[rd_ptr_q].last;
  assign out_o.error    = mem_q[rd_ptr_q].err;

  assign count_d = count_q + (QueueAw+1)'(burst_i.cnt) - (QueueAw+1)'(pop);

  // Store burst beats at consecutive slots
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < BurstMax; k++) begin
      if (3'(k) < burst_i.cnt) begin
        mem_q[wr_ptr_q + QueueAw'(k)] <= burst_i.ent[k];
      end
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueueAw'(burst_i.cnt);
      if (pop) rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ design/utf8_case_fold_transcoder.sv @@
// UTF-8 case fold transcoder: strict decode, simple case fold, re-encode.
// The decoder is combinational; its bursts are registered in the result queue before output.
// Throughput: one input byte per cycle while the 8-entry result queue has room for four
// beats; output drains one byte per cycle while ready, so the sustained input rate is
// set by output bytes per input byte (1 for ASCII, up to 4 on a sequence's final byte).
// Reset (rst_ni low, asynchronous) clears sequence state, discard flag and the queue.
`timescale 1ns / 1ps
`default_nettype none

module utf8_case_fold_transcoder
  import utf8cf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  utf8cf_in_if.sink     in_i,
  utf8cf_out_if.source  out_o
);

  burst_t burst;
  logic   space;
  logic   accept;

  // Take a byte whenever the queue can hold a full burst
  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  utf8cf_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.in_byte),
    .last_i   (in_i.in_last),
    .burst_o  (burst)
  );

  utf8cf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .burst_i (burst),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for the UTF-8 case fold transcoder: byte driver, beat checker, fold predictor.
// Depends on utf8cf_pkg, the utf8cf_in_if/utf8cf_out_if interfaces and the transcoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import utf8cf_pkg::*;

  typedef enum logic [0:0] {StepByte, StepDrain} step_kind_e;
  typedef enum int {FlawLead, FlawCont, FlawTrunc, FlawLong, FlawSurr, FlawRange} flaw_e;

  typedef struct {
    step_kind_e kind;
    logic [7:0] data;
    logic       last;
    int         gap;
  } feed_t;

  localparam int HoldAtBeat  = 40;
  localparam int HoldCycles  = 300;
  localparam int TargetBytes = 370;

  // Directed strings as {last, byte}: folds and the extremes, then each kind of bad input
  localparam logic [8:0] DirectedSeq [25] = '{
    9'h05A, 9'h0E2, 9'h084, 9'h0AA, 9'h0F4, 9'h08F, 9'h0BF, 9'h1BF, // Z, Kelvin, U+10FFFF
    9'h100,                                                         // NUL alone
    9'h0FF, 9'h141,                                                 // bad lead, dropped tail
    9'h1C1,                                                         // bad lead on last byte
    9'h0C3, 9'h141,                                                 // bad continuation
    9'h1E2,                                                         // truncated string
    9'h0E0, 9'h080, 9'h180,                                         // overlong
    9'h0ED, 9'h0A0, 9'h180,                                         // surrogate
    9'h0F4, 9'h090, 9'h080, 9'h180                                  // beyond U+10FFFF
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       drv_valid = 1'b0;
  logic [7:0] drv_byte  = 8'h00;
  logic       drv_last  = 1'b0;
  logic       drv_ready = 1'b0;

  utf8cf_in_if  src_if ();
  utf8cf_out_if dst_if ();

  assign src_if.valid   = drv_valid;
  assign src_if.in_byte = drv_byte;
  assign src_if.in_last = drv_last;
  assign dst_if.ready   = drv_ready;

  utf8_case_fold_transcoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (src_if),
    .out_o  (dst_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic [20:0] cp_acc    = '0;
  logic [1:0]  cont_left = '0;
  logic [1:0]  len_cls   = '0;
  logic        dropping  = 1'b0;

  entry_t folded_bytes_q [$];
  feed_t  byte_feed [$];
  int     bad_beats = 0;
  int     fed_bytes = 0;
  bit     quiet_src = 1'b0;

  // Simple case fold over the covered scripts
  function automatic logic [20:0] fold_simple(input logic [20:0] v);
    if (v >= 21'h41 && v <= 21'h5A) return v + 21'h20;
    if ((v >= 21'hC0 && v <= 21'hD6) || (v >= 21'hD8 && v <= 21'hDE)) return v + 21'h20;
    if (v == 21'h178) return 21'hFF;
    if (v >= 21'h100 && v <= 21'h177 && !v[0]) return v + 21'h1;
    if (v >= 21'h391 && v <= 21'h3A1) return v + 21'h20;
    if (v >= 21'h3A3 && v <= 21'h3AB) return v + 21'h20;
    if (v == 21'h3C2) return 21'h3C3;
    if (v >= 21'h410 && v <= 21'h42F) return v + 21'h20;
    if (v >= 21'h400 && v <= 21'h40F) return v + 21'h50;
    if (v >= 21'hFF21 && v <= 21'hFF3A) return v + 21'h20;
    if (v == 21'h1E9E) return 21'hDF;
    if (v == 21'h212A) return 21'h6B;
    return v;
  endfunction

  function automatic int utf8_len(input logic [20:0] cp);
    if (cp <= 21'h7F) return 1;
    if (cp <= 21'h7FF) return 2;
    if (cp <= 21'hFFFF) return 3;
    return 4;
  endfunction

  // Byte k of the n-byte encoding of cp (n may exceed the natural length)
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input int n, input int k);
    logic [20:0] sh;
    sh = cp >> (6 * (n - 1 - k));
    if (k > 0) return {2'b10, sh[5:0]};
    case (n)
      1: return {1'b0, sh[6:0]};
      2: return {3'b110, sh[4:0]};
      3: return {4'b1110, sh[3:0]};
      default: return {5'b11110, sh[2:0]};
    endcase
  endfunction

  // Abort the string: one error beat, clear the sequence, drop up to last if needed
  function automatic void flag_error(input logic lst);
    entry_t fault_beat;
    fault_beat = '{data: 8'h00, last: 1'b1, err: 1'b1};
    folded_bytes_q = {folded_bytes_q, fault_beat};
    cp_acc    = '0;
    cont_left = '0;
    len_cls   = '0;
    dropping  = !lst;
  endfunction

  function automatic void emit_folded(input logic [20:0] cp, input logic lst);
    int n;
    entry_t out_beat;
    n = utf8_len(cp);
    for (int k = 0; k < n; k++) begin
      out_beat = '{data: utf8_byte(cp, n, k), last: lst && (k == n - 1), err: 1'b0};
      folded_bytes_q = {folded_bytes_q, out_beat};
    end
  endfunction

  // Decode one accepted byte and queue the folded beats it produces
  function automatic void transcode_byte(input logic [7:0] b, input logic lst);
    logic [20:0] cp;
    logic [20:0] floor_cp;
    if (dropping) begin
      if (lst) dropping = 1'b0;
      return;
    end
    if (cont_left == 2'd0) begin
      if (b < 8'h80) begin
        emit_folded(fold_simple({13'd0, b}), lst);
        return;
      end
      if (b >= 8'hC2 && b <= 8'hDF) begin
        cp_acc = {16'd0, b[4:0]};
        len_cls = LenTwo;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        cp_acc = {17'd0, b[3:0]};
        len_cls = LenThree;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        cp_acc = {18'd0, b[2:0]};
        len_cls = LenFour;
      end else begin
        flag_error(lst);
        return;
      end
      cont_left = len_cls;
      if (lst) flag_error(lst);
      return;
    end
    if (b[7:6] != 2'b10) begin
      flag_error(lst);
      return;
    end
    cp_acc = {cp_acc[14:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left != 2'd0) begin
      if (lst) flag_error(lst);
      return;
    end
    cp = cp_acc;
    floor_cp = (len_cls == LenTwo) ? MinTwo : (len_cls == LenThree) ? MinThree : MinFour;
    cp_acc = '0;
    len_cls = '0;
    if (cp < floor_cp || cp > CpMax || (cp >= SurrLo && cp <= SurrHi)) flag_error(lst);
    else emit_folded(fold_simple(cp), lst);
  endfunction

  // Stimulus helpers
  function automatic void push_byte(input logic [7:0] b, input logic lst);
    feed_t pend;
    pend = '{kind: StepByte, data: b, last: lst,
             gap: quiet_src ? 0 : $urandom_range(0, 18)};
    byte_feed = {byte_feed, pend};
    fed_bytes++;
  endfunction

  function automatic void push_drain();
    feed_t pend;
    pend = '{kind: StepDrain, data: 8'h00, last: 1'b0, gap: 0};
    byte_feed = {byte_feed, pend};
  endfunction

  function automatic void push_cp(input logic [20:0] cp, input int n, input logic fin);
    for (int k = 0; k < n; k++) push_byte(utf8_byte(cp, n, k), fin && (k == n - 1));
  endfunction

  function automatic logic [20:0] random_cp();
    logic [20:0] cp;
    case ($urandom_range(0, 8))
      0: cp = 21'($urandom_range(0, 'h7F));
      1: cp = 21'($urandom_range('h41, 'h5A));
      2: cp = 21'($urandom_range('hC0, 'h17F));
      3: cp = 21'($urandom_range('h370, 'h45F));
      4: cp = 21'($urandom_range('h80, 'h7FF));
      5: begin
        cp = 21'($urandom_range('h800, 'hF7FF));
        if (cp >= 21'hD800) cp = cp + 21'h800;
      end
      6: cp = 21'($urandom_range('hFF10, 'hFF5F));
      7: cp = 21'($urandom_range('h10000, 'h10FFFF));
      default: begin
        case ($urandom_range(0, 15))
          0: cp = 21'h178;
          1: cp = 21'h1E9E;
          2: cp = 21'h212A;
          3: cp = 21'h3C2;
          4: cp = 21'h7F;
          5: cp = 21'h80;
          6: cp = 21'h7FF;
          7: cp = 21'h800;
          8: cp = 21'hFFFF;
          9: cp = 21'h10000;
          10: cp = 21'h10FFFF;
          11: cp = 21'hD7FF;
          12: cp = 21'hE000;
          13: cp = 21'h3A2;
          14: cp = 21'hD7;
          default: cp = 21'hDF;
        endcase
      end
    endcase
    return cp;
  endfunction

  function automatic logic [20:0] random_wide_cp();
    logic [20:0] cp;
    cp = random_cp();
    while (cp <= 21'h7F) cp = random_cp();
    return cp;
  endfunction

  // Queue one malformed piece; returns 1 when it already closed the string
  function automatic bit push_flaw(input flaw_e kind, input logic fin);
    logic [20:0] cp;
    int n;
    int k;
    case (kind)
      FlawLead: begin
        push_byte(8'($urandom_range(0, 1) ? $urandom_range('h80, 'hC1)
                                          : $urandom_range('hF5, 'hFF)), fin);
      end
      FlawCont, FlawTrunc: begin
        cp = random_wide_cp();
        n = utf8_len(cp);
        k = $urandom_range(1, n - 1);
        for (int i = 0; i < k; i++)
          push_byte(utf8_byte(cp, n, i), kind == FlawTrunc && i == k - 1);
        if (kind == FlawTrunc) return 1'b1;
        push_byte(8'($urandom_range(0, 1) ? $urandom_range(0, 'h7F)
                                          : $urandom_range('hC0, 'hFF)), fin);
      end
      FlawLong: begin
        n = $urandom_range(2, 4);
        cp = 21'($urandom_range(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF));
        push_cp(cp, n, fin);
      end
      FlawSurr: push_cp(21'($urandom_range('hD800, 'hDFFF)), 3, fin);
      default: push_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4, fin);
    endcase
    return 1'b0;
  endfunction

  // One random string: mostly well formed, some with a single flaw, some raw noise
  function automatic void push_string();
    int ncp;
    int roll;
    int flaw_at;
    int nb;
    logic [20:0] cp;
    ncp = $urandom_range(1, 6);
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      nb = $urandom_range(1, 8);
      for (int i = 0; i < nb; i++) push_byte(8'($urandom_range(0, 255)), i == nb - 1);
      return;
    end
    flaw_at = (roll < 40) ? $urandom_range(0, ncp - 1) : -1;
    for (int i = 0; i < ncp; i++) begin
      if (i == flaw_at) begin
        if (push_flaw(flaw_e'($urandom_range(0, 5)), i == ncp - 1)) return;
      end else begin
        cp = random_cp();
        push_cp(cp, utf8_len(cp), i == ncp - 1);
      end
    end
  endfunction

  // Input driver: offer bytes from the feed, hold on drain markers until all beats are out
  bit armed     = 1'b0;
  int idle_left = 0;

  always @(posedge clk_i) begin : byte_driver
    feed_t head;
    logic  offer;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      offer = drv_valid;
      if (drv_valid && src_if.ready) begin
        transcode_byte(drv_byte, drv_last);
        offer = 1'b0;
      end
      if (!offer && byte_feed.size() != 0) begin
        head = byte_feed[0];
        if (head.kind == StepDrain) begin
          if (folded_bytes_q.size() == 0) void'(byte_feed.pop_front());
        end else begin
          if (!armed) begin
            idle_left = head.gap;
            armed = 1'b1;
          end
          if (idle_left > 0) begin
            idle_left--;
          end else begin
            void'(byte_feed.pop_front());
            drv_byte <= head.data;
            drv_last <= head.last;
            offer = 1'b1;
            armed = 1'b0;
          end
        end
      end
      drv_valid <= offer;
    end
  end

  // Output side: check each beat against the oldest prediction, then stall at random
  int  beats_seen = 0;
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  quiet_snk  = 1'b0;

  always @(posedge clk_i) begin : beat_checker
    entry_t want;
    logic   rdy;
    if (!rst_ni) begin
      drv_ready <= 1'b0;
    end else begin
      if (dst_if.valid && drv_ready) begin
        beats_seen++;
        if (folded_bytes_q.size() == 0) begin
          bad_beats++;
          $display("%0t: unexpected beat: expected none, got byte %h last %b error %b",
                   $time, dst_if.out_byte, dst_if.out_last, dst_if.error);
        end else begin
          want = folded_bytes_q.pop_front();
          if (dst_if.out_byte !== want.data || dst_if.out_last !== want.last ||
              dst_if.error !== want.err) begin
            bad_beats++;
            $display("%0t: mismatch: expected byte %h last %b error %b, %s %h %s %b %s %b",
                     $time, want.data, want.last, want.err,
                     "got byte", dst_if.out_byte, "last", dst_if.out_last,
                     "error", dst_if.error);
          end
        end
        stall_left = quiet_snk ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 29) == 0) quiet_snk = !quiet_snk;
        // Long back-pressure once so the result queue fills and input stalls
        if (beats_seen == HoldAtBeat) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      drv_ready <= rdy;
    end
  end

  // Build the stimulus, run reset, wait for the drain and report
  initial begin
    foreach (DirectedSeq[i]) push_byte(DirectedSeq[i][7:0], DirectedSeq[i][8]);
    push_drain();
    while (fed_bytes < TargetBytes) begin
      if ($urandom_range(0, 7) == 0) quiet_src = !quiet_src;
      push_string();
      if ($urandom_range(0, 19) == 0) push_drain();
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (byte_feed.size() != 0 || drv_valid) @(posedge clk_i);
    while (folded_bytes_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (folded_bytes_q.size() != 0) begin
      bad_beats++;
      $display("%0t: %0d predicted beats never arrived", $time, folded_bytes_q.size());
    end
    if (bad_beats == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
